/* rtl/crc32ws_pkg.sv */
// Shared types, constants and the bitwise byte step for the word-stream CRC-32.
// No dependencies; every other file of the block refers to it by scoped names.
package crc32ws_pkg;

  localparam int unsigned CrcW         = 32;
  localparam int unsigned DataW        = 32;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned CountW       = 3;
  // Widened lane count, able to hold the byte lane limit itself
  localparam int unsigned LaneCntW     = 4;
  // Byte lanes processed per word at most (1 to 8); lanes above bit 31 read as zero
  localparam int unsigned BytesPerWord = 4;

  localparam logic [CrcW-1:0]  CrcPoly  = 32'hEDB8_8320;
  localparam logic [ByteW-1:0] ByteMask = 8'hFF;

  typedef struct packed {
    logic [DataW-1:0]  data_word;
    logic [CountW-1:0] byte_count;
    logic              first_item;
    logic              last_item;
  } in_beat_t;

  // Eight reflected shift steps of one byte through the running value
  function automatic logic [CrcW-1:0] crc_byte(logic [CrcW-1:0] crc, logic [ByteW-1:0] data);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, data & ByteMask};
    for (int k = 0; k < ByteW; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/crc32ws_if.sv */
// Valid/ready stream interfaces for the word-stream CRC-32 input and result beats.
// Depends on crc32ws_pkg for field widths.
interface crc32ws_in_if;
  logic                               valid;
  logic                               ready;
  logic [crc32ws_pkg::DataW-1:0]      data_word;
  logic [crc32ws_pkg::CountW-1:0]     byte_count;
  logic                               first_item;
  logic                               last_item;

  modport source (output valid, data_word, byte_count, first_item, last_item, input ready);
  modport sink   (input valid, data_word, byte_count, first_item, last_item, output ready);
endinterface

interface crc32ws_out_if;
  logic                           valid;
  logic                           ready;
  logic [crc32ws_pkg::CrcW-1:0]   crc_value;
  logic                           is_final;

  modport source (output valid, crc_value, is_final, input ready);
  modport sink   (input valid, crc_value, is_final, output ready);
endinterface

/* rtl/crc32_word_stream.sv */
// Top level of the word-stream CRC-32: input register, CRC update, result register.
// Depends on crc32ws_pkg, the interfaces in crc32ws_if.sv and crc32ws_update.
//
// Use:
//   in_i carries one memory word per beat: data_word (bytes taken lowest first),
//   byte_count (valid bytes from the low end, saturated at four), first_item
//   (restart from the initial value) and last_item (echoed as is_final).
//   out_o gives one beat per input beat: the running CRC after that word, reflected
//   polynomial 0xEDB88320, no inversion on the way in or out.
//   cfg_we_i / cfg_wdata_i write the initial value; write it only while idle.
// Throughput: one beat per cycle while out_o is ready. The word is held in an input
//   register, the four byte lanes of the update logic run in a single pass and the
//   result register takes the new CRC, which also becomes the running value for the
//   next word.
// Stall: while out_o is held off the result stays put; the input register can still
//   take one more beat, after which in_i.ready drops until the result is taken.
// Reset: drops both stages, clears the running CRC and the initial value to zero.
module crc32_word_stream (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  crc32ws_in_if.sink                         in_i,
  crc32ws_out_if.source                      out_o,
  input  logic                               cfg_we_i,
  input  logic [crc32ws_pkg::CrcW-1:0]       cfg_wdata_i
);

  logic                          s1_valid_q;
  crc32ws_pkg::in_beat_t         s1_beat_q;
  logic                          out_valid_q;
  logic [crc32ws_pkg::CrcW-1:0]  out_crc_q;
  logic                          out_final_q;
  logic [crc32ws_pkg::CrcW-1:0]  running_crc_q;
  logic [crc32ws_pkg::CrcW-1:0]  init_value_q;
  logic [crc32ws_pkg::CrcW-1:0]  crc_d;
  logic                          out_free;
  logic                          s1_adv;
  logic                          in_take;

  // Result slot is free when empty or being emptied this cycle
  assign out_free     = !out_valid_q || out_o.ready;
  assign s1_adv       = s1_valid_q && out_free;
  assign in_i.ready   = !s1_valid_q || out_free;
  assign in_take      = in_i.valid && in_i.ready;

  // Hold the initial value between writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_value_q <= '0;
    end else if (cfg_we_i) begin
      init_value_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_beat_q.data_word  <= in_i.data_word;
      s1_beat_q.byte_count <= in_i.byte_count;
      s1_beat_q.first_item <= in_i.first_item;
      s1_beat_q.last_item  <= in_i.last_item;
    end
  end

  crc32ws_update u_update (
    .beat_i        (s1_beat_q),
    .init_value_i  (init_value_q),
    .running_crc_i (running_crc_q),
    .crc_o         (crc_d)
  );

  // Result register and running value advance together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      running_crc_q <= '0;
    end else begin
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        running_crc_q <= crc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_crc_q   <= crc_d;
      out_final_q <= s1_beat_q.last_item;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.crc_value = out_crc_q;
  assign out_o.is_final  = out_final_q;

  // A beat that moves on appears as the result and as the running value
  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (out_valid_q && (out_crc_q == running_crc_q)))
    else $error("result and running CRC differ after an advance");

  // A stalled result freezes the running value
  a_stall_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> $stable(running_crc_q))
    else $error("running CRC moved while the result was stalled");

  // A full input register takes a new beat only when its own beat moves on
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && s1_valid_q) |-> s1_adv)
    else $error("input register overwritten");

  // A held beat keeps its payload
  a_hold_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_beat_q)))
    else $error("held input beat changed");

endmodule

/* rtl/crc32ws_update.sv */
// Combinational CRC update of one word: start-value select and a chain of byte lanes.
// Depends on crc32ws_pkg (in_beat_t, crc_byte, BytesPerWord).
module crc32ws_update (
  input  crc32ws_pkg::in_beat_t        beat_i,
  input  logic [crc32ws_pkg::CrcW-1:0] init_value_i,
  input  logic [crc32ws_pkg::CrcW-1:0] running_crc_i,
  output logic [crc32ws_pkg::CrcW-1:0] crc_o
);

  localparam int unsigned Lanes = crc32ws_pkg::BytesPerWord;
  localparam int unsigned CntW  = crc32ws_pkg::LaneCntW;
  localparam int unsigned ByteW = crc32ws_pkg::ByteW;

  logic [CntW-1:0]              cnt_ext;
  logic [CntW-1:0]              cnt_sat;
  logic [crc32ws_pkg::CrcW-1:0] chain [Lanes+1];

  // Saturate the byte count at the lane limit
  assign cnt_ext  = {{(CntW-crc32ws_pkg::CountW){1'b0}}, beat_i.byte_count};
  assign cnt_sat  = (cnt_ext > CntW'(Lanes)) ? CntW'(Lanes) : cnt_ext;
  assign chain[0] = beat_i.first_item ? init_value_i : running_crc_i;

  for (genvar k = 0; k < Lanes; k++) begin : g_lane
    logic [ByteW-1:0] lane_byte;
    if ((k + 1) * ByteW <= crc32ws_pkg::DataW) begin : g_data
      assign lane_byte = beat_i.data_word[k*ByteW +: ByteW];
    end else begin : g_zero
      assign lane_byte = '0;
    end
    assign chain[k+1] = (CntW'(k) < cnt_sat) ? crc32ws_pkg::crc_byte(chain[k], lane_byte)
                                             : chain[k];
  end

  assign crc_o = chain[Lanes];

endmodule
